[hw/rtl/ipv4_range_allowlist_table_core_macros.svh]
// assertion macros shared by the checker
`ifndef IPV4_RANGE_ALLOWLIST_TABLE_CORE_MACROS_SVH
`define IPV4_RANGE_ALLOWLIST_TABLE_CORE_MACROS_SVH

// concurrent assertion on clk_i, off while rst_ni is low
`define IRAT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("irat assertion failed");

// implication form
`define IRAT_ASSERT_IMP(label, ante, cons) \
  `IRAT_ASSERT(label, (ante) |-> (cons))

`endif

[hw/rtl/irat_pkg.sv]
`timescale 1ns / 1ps
package irat_pkg;

  localparam int unsigned TableDepthDefault = 256;
  localparam logic [31:0] TopAddr = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_COMPILE = 2'd1,
    FUNC_LOOKUP  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_INVERTED = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PUSH,
    CELL_ROT,
    CELL_SORT
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     phase;
  } cell_ctrl_t;

  typedef struct packed {
    logic        v;
    logic [31:0] lo;
    logic [31:0] hi;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT1,
    S_MERGE,
    S_SORT2,
    S_SCAN
  } state_e;

endpackage

[hw/rtl/irat_cell.sv]
`timescale 1ns / 1ps
module irat_cell #(
  parameter bit OddPos = 1'b0,
  parameter bit First  = 1'b0,
  parameter bit Last   = 1'b0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  irat_pkg::cell_ctrl_t ctrl_i,
  input  irat_pkg::entry_t    left_i,
  input  irat_pkg::entry_t    right_i,
  output irat_pkg::entry_t    data_o
);

  irat_pkg::entry_t ent_q, ent_d;
  logic [32:0] key_own, key_left, key_right;
  logic        pair_right;

  assign key_own   = {~ent_q.v, ent_q.lo};
  assign key_left  = {~left_i.v, left_i.lo};
  assign key_right = {~right_i.v, right_i.lo};
  assign pair_right = (ctrl_i.phase == OddPos);

  always_comb begin
    ent_d = ent_q;
    unique case (ctrl_i.op)
      irat_pkg::CELL_HOLD: ent_d = ent_q;
      irat_pkg::CELL_PUSH: ent_d = left_i;
      irat_pkg::CELL_ROT:  ent_d = right_i;
      irat_pkg::CELL_SORT: begin
        // compare-swap with the partner of this phase, smaller key to the left
        if (pair_right && !Last) begin
          if (key_own > key_right) ent_d = right_i;
        end else if (!pair_right && !First) begin
          if (key_left > key_own) ent_d = left_i;
        end
      end
      default: ent_d = ent_q;
    endcase
  end

  // only the valid bit is reset, range data follows its writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q.v <= 1'b0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign data_o = ent_q;

endmodule

[hw/rtl/ipv4_range_allowlist_table_core.sv]
`timescale 1ns / 1ps
// push and unknown codes: result registered in the cycle after start, next start taken right away
// lookup: one cell read per cycle past cell 0, result after the full rotation of the table
// compile: sort, merge rotation, then sort again; empty table: result in the cycle after start
// busy is high while a lookup or compile runs; done_o pulses once, receiver cannot stall
// reset clears all valid bits and the range count; range data is not reset
module ipv4_range_allowlist_table_core #(
  parameter int unsigned TABLE_DEPTH = irat_pkg::TableDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [31:0] address_i,
  input  logic [31:0] range_high_i,
  output logic        done_o,
  output logic        hit_o,
  output logic [1:0]  status_o,
  output logic [8:0]  entry_count_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 2);
  localparam int unsigned CountW = $clog2(TABLE_DEPTH + 1);

  // chain of range cells, cell 0 is the head
  irat_pkg::entry_t     chain [TABLE_DEPTH];
  irat_pkg::entry_t     push_ent;
  irat_pkg::entry_t     tail_in;
  irat_pkg::cell_ctrl_t ctrl;

  irat_pkg::state_e  state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] merged_q, merged_d;
  irat_pkg::entry_t  cur_q, cur_d;
  irat_pkg::entry_t  mout;
  logic [31:0]       addr_q, addr_d;
  logic              hit_acc_q, hit_acc_d;
  logic              done_q, done_d;
  logic              hit_q, hit_d;
  logic [1:0]        status_q, status_d;
  logic              head_match;
  logic              accept;

  assign accept = start && (state_q == irat_pkg::S_IDLE);
  assign push_ent = '{v: 1'b1, lo: address_i, hi: range_high_i};

  // lookup compare on whatever sits in cell 0
  assign head_match = chain[0].v && (addr_q >= chain[0].lo) && (addr_q <= chain[0].hi);

  // merge unit: holds the open range, emits it when the next sorted range neither
  // overlaps nor touches it; an invalid input flushes the open range
  always_comb begin
    mout  = '0;
    cur_d = cur_q;
    if (!chain[0].v) begin
      mout    = cur_q;
      cur_d.v = 1'b0;
    end else if (!cur_q.v) begin
      cur_d = chain[0];
    end else if (cur_q.hi == irat_pkg::TopAddr) begin
      // open range already reaches the top address, absorb
      cur_d = cur_q;
    end else if (({1'b0, cur_q.hi} + 33'd1) >= {1'b0, chain[0].lo}) begin
      if (cur_q.hi < chain[0].hi) cur_d.hi = chain[0].hi;
    end else begin
      mout  = cur_q;
      cur_d = chain[0];
    end
  end

  // next state, cell control and result
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    count_d   = count_q;
    merged_d  = merged_q;
    addr_d    = addr_q;
    hit_acc_d = hit_acc_q;
    done_d    = 1'b0;
    hit_d     = hit_q;
    status_d  = status_q;
    ctrl      = '{op: irat_pkg::CELL_HOLD, phase: cnt_q[0]};
    tail_in   = chain[0];
    unique case (state_q)
      irat_pkg::S_IDLE: begin
        if (accept) begin
          cnt_d     = '0;
          addr_d    = address_i;
          hit_acc_d = 1'b0;
          hit_d     = 1'b0;
          status_d  = irat_pkg::ST_OK;
          priority if (func_i == irat_pkg::FUNC_PUSH) begin
            done_d = 1'b1;
            if (count_q == CountW'(TABLE_DEPTH)) begin
              status_d = irat_pkg::ST_FULL;
            end else if (range_high_i < address_i) begin
              status_d = irat_pkg::ST_INVERTED;
            end else begin
              ctrl.op = irat_pkg::CELL_PUSH;
              count_d = count_q + CountW'(1);
            end
          end else if (func_i == irat_pkg::FUNC_COMPILE) begin
            if (count_q == '0) begin
              done_d = 1'b1;
            end else begin
              state_d = irat_pkg::S_SORT1;
            end
          end else if (func_i == irat_pkg::FUNC_LOOKUP) begin
            state_d = irat_pkg::S_SCAN;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      irat_pkg::S_SORT1: begin
        ctrl.op = irat_pkg::CELL_SORT;
        cnt_d   = cnt_q + CntW'(1);
        if (cnt_q == CntW'(TABLE_DEPTH - 1)) begin
          cnt_d    = '0;
          merged_d = '0;
          state_d  = irat_pkg::S_MERGE;
        end
      end
      irat_pkg::S_MERGE: begin
        // one extra step so the leading bubble flushes the last open range
        ctrl.op = irat_pkg::CELL_ROT;
        tail_in = mout;
        cnt_d   = cnt_q + CntW'(1);
        if (mout.v) merged_d = merged_q + CountW'(1);
        if (cnt_q == CntW'(TABLE_DEPTH)) begin
          cnt_d   = '0;
          state_d = irat_pkg::S_SORT2;
        end
      end
      irat_pkg::S_SORT2: begin
        // pushes merged ranges ahead of the bubbles
        ctrl.op = irat_pkg::CELL_SORT;
        cnt_d   = cnt_q + CntW'(1);
        if (cnt_q == CntW'(TABLE_DEPTH - 1)) begin
          // new range count shows together with the result
          count_d = merged_q;
          state_d = irat_pkg::S_IDLE;
          done_d  = 1'b1;
        end
      end
      irat_pkg::S_SCAN: begin
        ctrl.op   = irat_pkg::CELL_ROT;
        tail_in   = chain[0];
        hit_acc_d = hit_acc_q | head_match;
        cnt_d     = cnt_q + CntW'(1);
        if (cnt_q == CntW'(TABLE_DEPTH - 1)) begin
          state_d = irat_pkg::S_IDLE;
          done_d  = 1'b1;
          hit_d   = hit_acc_d;
        end
      end
      default: state_d = irat_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= irat_pkg::S_IDLE;
      cnt_q   <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
      cur_q.v <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      count_q <= count_d;
      done_q  <= done_d;
      // open range is empty at the start of each merge rotation
      cur_q   <= '{v: (state_q == irat_pkg::S_MERGE) ? cur_d.v : 1'b0,
                   lo: cur_d.lo, hi: cur_d.hi};
    end
  end

  always_ff @(posedge clk_i) begin
    merged_q  <= merged_d;
    addr_q    <= addr_d;
    hit_acc_q <= hit_acc_d;
    hit_q     <= hit_d;
    status_q  <= status_d;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    irat_pkg::entry_t left_n, right_n;
    if (i == 0) begin : g_first
      assign left_n = push_ent;
    end else begin : g_mid_l
      assign left_n = chain[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign right_n = tail_in;
    end else begin : g_mid_r
      assign right_n = chain[i+1];
    end
    irat_cell #(
      .OddPos(i % 2 == 1),
      .First (i == 0),
      .Last  (i == TABLE_DEPTH - 1)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .left_i (left_n),
      .right_i(right_n),
      .data_o (chain[i])
    );
  end

  assign busy          = (state_q != irat_pkg::S_IDLE);
  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign status_o      = status_q;
  assign entry_count_o = 9'(count_q);

endmodule

[hw/rtl/irat_checker.sv]
`timescale 1ns / 1ps
`include "ipv4_range_allowlist_table_core_macros.svh"
module irat_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic       hit_o,
  input logic [1:0] status_o,
  input logic [8:0] entry_count_o
);

  // a result follows an accepted transaction or the end of a busy stretch
  `IRAT_ASSERT_IMP(a_done_cause, done_o, $past(start && !busy) || $past(busy))
  // a hit only comes with ok status
  `IRAT_ASSERT_IMP(a_hit_ok, done_o && hit_o, status_o == irat_pkg::ST_OK)
  // the range count only moves together with a result
  `IRAT_ASSERT_IMP(a_count_moves, !$stable(entry_count_o), done_o)
  // busy ends with a result
  `IRAT_ASSERT_IMP(a_busy_end, $fell(busy), done_o)

endmodule

bind ipv4_range_allowlist_table_core irat_checker u_irat_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .hit_o        (hit_o),
  .status_o     (status_o),
  .entry_count_o(entry_count_o)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned Depth = irat_pkg::TableDepthDefault;
  localparam int unsigned StallLimit = 20000;
  // code with no function behind it
  localparam logic [1:0] FuncUnused = 2'd3;

  typedef struct {
    logic              hit;
    irat_pkg::status_e status;
    logic [8:0]        entry_count;
  } verdict_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  func_i;
  logic [31:0] address_i;
  logic [31:0] range_high_i;
  logic        done_o;
  logic        hit_o;
  logic [1:0]  status_o;
  logic [8:0]  entry_count_o;

  // shadow copy of the range table
  logic [31:0] tbl_lo [Depth];
  logic [31:0] tbl_hi [Depth];
  int unsigned tbl_count;
  bit          tbl_compiled;

  verdict_t    pending_verdicts[$];
  int unsigned n_fail;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_hits;
  int unsigned n_full;
  int unsigned n_inverted;
  int unsigned n_compiles;
  int unsigned idle_cycles;
  bit          no_idle;

  ipv4_range_allowlist_table_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .address_i    (address_i),
    .range_high_i (range_high_i),
    .done_o       (done_o),
    .hit_o        (hit_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sort by low address, then fold overlapping or touching ranges together
  function automatic void merge_table();
    logic [31:0] lo;
    logic [31:0] hi;
    int          j;
    int unsigned dst;
    if (tbl_count == 0) return;
    for (int i = 1; i < tbl_count; i++) begin
      lo = tbl_lo[i];
      hi = tbl_hi[i];
      j = i;
      while (j > 0 && tbl_lo[j-1] > lo) begin
        tbl_lo[j] = tbl_lo[j-1];
        tbl_hi[j] = tbl_hi[j-1];
        j--;
      end
      tbl_lo[j] = lo;
      tbl_hi[j] = hi;
    end
    dst = 0;
    for (int i = 1; i < tbl_count; i++) begin
      // a range ending at the top address swallows everything after it
      if (tbl_hi[dst] == irat_pkg::TopAddr) continue;
      // compare done at 33 bits so no wrap-around
      if ({1'b0, tbl_hi[dst]} + 33'd1 >= {1'b0, tbl_lo[i]}) begin
        if (tbl_hi[dst] < tbl_hi[i]) tbl_hi[dst] = tbl_hi[i];
      end else begin
        dst++;
        tbl_lo[dst] = tbl_lo[i];
        tbl_hi[dst] = tbl_hi[i];
      end
    end
    tbl_count = dst + 1;
    tbl_compiled = 1'b1;
  endfunction

  function automatic logic search_table(logic [31:0] addr);
    int left;
    int right;
    int mid;
    if (tbl_compiled) begin
      left = 0;
      right = int'(tbl_count) - 1;
      while (left <= right) begin
        mid = (left + right) / 2;
        if (addr < tbl_lo[mid]) right = mid - 1;
        else if (addr > tbl_hi[mid]) left = mid + 1;
        else return 1'b1;
      end
    end else begin
      for (int i = 0; i < tbl_count; i++)
        if (addr >= tbl_lo[i] && addr <= tbl_hi[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // expected outcome of one accepted transaction, updates the shadow table
  function automatic verdict_t predict_verdict(logic [1:0] fn, logic [31:0] addr,
                                               logic [31:0] high);
    verdict_t v;
    v.hit = 1'b0;
    v.status = irat_pkg::ST_OK;
    case (fn)
      irat_pkg::FUNC_PUSH: begin
        // a refused push still drops the compiled mark
        tbl_compiled = 1'b0;
        if (tbl_count >= Depth) begin
          v.status = irat_pkg::ST_FULL;
        end else if (high < addr) begin
          v.status = irat_pkg::ST_INVERTED;
        end else begin
          tbl_lo[tbl_count] = addr;
          tbl_hi[tbl_count] = high;
          tbl_count++;
        end
      end
      irat_pkg::FUNC_COMPILE: merge_table();
      irat_pkg::FUNC_LOOKUP: v.hit = search_table(addr);
      default: ;
    endcase
    v.entry_count = tbl_count[8:0];
    return v;
  endfunction

  // drive one transaction; start stays high when the next one follows directly
  task automatic send_item(logic [1:0] fn, logic [31:0] addr, logic [31:0] high);
    verdict_t v;
    while (!no_idle && ($urandom_range(99) < 21)) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    func_i       <= fn;
    address_i    <= addr;
    range_high_i <= high;
    do @(posedge clk_i); while (busy);
    v = predict_verdict(fn, addr, high);
    pending_verdicts.push_back(v);
    n_sent++;
    if (fn == irat_pkg::FUNC_COMPILE) n_compiles++;
    if (v.status == irat_pkg::ST_FULL) n_full++;
    if (v.status == irat_pkg::ST_INVERTED) n_inverted++;
  endtask

  // result checker, every strobe must match the oldest expectation
  always @(posedge clk_i) begin
    verdict_t v;
    if (rst_ni && done_o) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result: hit %0b status %0d entry_count %0d",
               hit_o, status_o, entry_count_o);
        n_fail++;
      end else begin
        v = pending_verdicts.pop_front();
        n_checked++;
        if (v.hit) n_hits++;
        if (hit_o !== v.hit) begin
          $error("hit: expected %0b, actual %0b", v.hit, hit_o);
          n_fail++;
        end
        if (status_o !== v.status) begin
          $error("status: expected %0d, actual %0d", v.status, status_o);
          n_fail++;
        end
        if (entry_count_o !== v.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", v.entry_count, entry_count_o);
          n_fail++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction and no result
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("watchdog expired, no progress for %0d cycles", StallLimit);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // address near a stored boundary, or anywhere
  function automatic logic [31:0] probe_addr();
    int unsigned k;
    if (tbl_count == 0 || $urandom_range(3) == 0) return $urandom();
    k = $urandom_range(tbl_count - 1);
    case ($urandom_range(3))
      0: return tbl_lo[k] - 32'd1;
      1: return tbl_lo[k];
      2: return tbl_hi[k];
      default: return tbl_hi[k] + 32'd1;
    endcase
  endfunction

  task automatic test_directed();
    send_item(irat_pkg::FUNC_LOOKUP, 32'h0, 32'h0);             // empty table
    send_item(irat_pkg::FUNC_COMPILE, 32'h0, 32'h0);            // compile of empty table
    send_item(irat_pkg::FUNC_LOOKUP, irat_pkg::TopAddr, 32'h0);
    send_item(FuncUnused, irat_pkg::TopAddr, irat_pkg::TopAddr);
    send_item(irat_pkg::FUNC_PUSH, 32'h10, 32'hF);              // high below low
    send_item(irat_pkg::FUNC_PUSH, irat_pkg::TopAddr, 32'h0);
    send_item(irat_pkg::FUNC_PUSH, 32'h0, 32'h0);
    send_item(irat_pkg::FUNC_PUSH, irat_pkg::TopAddr, irat_pkg::TopAddr);
    send_item(irat_pkg::FUNC_PUSH, 32'h100, 32'h1FF);
    send_item(irat_pkg::FUNC_PUSH, 32'h200, 32'h2FF);           // touches the previous
    send_item(irat_pkg::FUNC_PUSH, 32'h250, 32'h260);           // overlap, inside
    send_item(irat_pkg::FUNC_LOOKUP, 32'h1FF, 32'h0);           // linear scan
    send_item(irat_pkg::FUNC_LOOKUP, 32'h300, 32'h0);
    send_item(irat_pkg::FUNC_COMPILE, 32'h0, 32'h0);
    send_item(irat_pkg::FUNC_LOOKUP, 32'h200, 32'h0);           // binary search
    send_item(irat_pkg::FUNC_LOOKUP, 32'h1, 32'h0);
    send_item(irat_pkg::FUNC_LOOKUP, irat_pkg::TopAddr, 32'h0);
    send_item(irat_pkg::FUNC_LOOKUP, 32'hFFFF_FFFE, 32'h0);
    send_item(irat_pkg::FUNC_PUSH, 32'h8000_0000, irat_pkg::TopAddr); // ends at the top
    send_item(irat_pkg::FUNC_PUSH, 32'h9000_0000, 32'h9000_0010);
    send_item(irat_pkg::FUNC_COMPILE, 32'h0, 32'h0);            // top range absorbs later ones
    send_item(irat_pkg::FUNC_LOOKUP, 32'h9000_0000, 32'h0);
    send_item(irat_pkg::FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h0);
  endtask

  task automatic test_random(int unsigned n_items);
    logic [31:0] base;
    logic [31:0] lo;
    int unsigned issued;
    int unsigned k;
    issued = 0;
    while (issued < n_items) begin
      // quiet stretch with back-to-back transactions
      no_idle = (issued >= 500 && issued < 800);
      if (tbl_count > 200) begin
        send_item(irat_pkg::FUNC_PUSH, 32'h0, irat_pkg::TopAddr);
        send_item(irat_pkg::FUNC_COMPILE, $urandom(), $urandom());
        issued += 2;
      end
      // clustered ranges so that compiles actually merge
      base = ($urandom_range(3) == 0) ? $urandom()
                                      : {2'($urandom_range(3)), 30'h0} - 32'h800;
      k = $urandom_range(1, 10);
      for (int i = 0; i < k; i++) begin
        case ($urandom_range(9))
          0: send_item(irat_pkg::FUNC_PUSH, $urandom(), $urandom());
          1: send_item(FuncUnused, $urandom(), $urandom());
          2: begin
            lo = base + $urandom_range(4095);
            send_item(irat_pkg::FUNC_PUSH, lo, lo - $urandom_range(1, 16));
          end
          default: begin
            lo = base + $urandom_range(4095);
            send_item(irat_pkg::FUNC_PUSH, lo, lo + $urandom_range(300));
          end
        endcase
      end
      issued += k;
      if ($urandom_range(2) != 0) begin
        send_item(irat_pkg::FUNC_COMPILE, $urandom(), $urandom());
        issued++;
      end
      k = $urandom_range(3, 20);
      for (int i = 0; i < k; i++) send_item(irat_pkg::FUNC_LOOKUP, probe_addr(), $urandom());
      issued += k;
    end
    no_idle = 0;
  endtask

  // fill to capacity with disjoint ranges, then hammer both search modes
  task automatic test_full_table();
    logic [31:0] lo;
    int unsigned i;
    i = 0;
    while (tbl_count < Depth) begin
      lo = 32'h4000_0000 + i * 16;
      send_item(irat_pkg::FUNC_PUSH, lo, lo + 32'd7);
      i++;
    end
    send_item(irat_pkg::FUNC_PUSH, 32'h1, 32'h2);               // table full
    send_item(irat_pkg::FUNC_PUSH, 32'h9, 32'h2);               // full wins over inverted
    for (int j = 0; j < 20; j++) send_item(irat_pkg::FUNC_LOOKUP, probe_addr(), 32'h0);
    send_item(irat_pkg::FUNC_COMPILE, 32'h0, 32'h0);
    for (int j = 0; j < 60; j++) send_item(irat_pkg::FUNC_LOOKUP, probe_addr(), 32'h0);
    send_item(irat_pkg::FUNC_PUSH, irat_pkg::TopAddr, irat_pkg::TopAddr);
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    func_i       = irat_pkg::FUNC_PUSH;
    address_i    = '0;
    range_high_i = '0;
    n_fail = 0;
    n_sent = 0;
    n_checked = 0;
    n_hits = 0;
    n_full = 0;
    n_inverted = 0;
    n_compiles = 0;
    idle_cycles = 0;
    no_idle = 0;
    tbl_count = 0;
    tbl_compiled = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(1200);
    test_full_table();

    start <= 1'b0;
    while (pending_verdicts.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("sent %0d transactions, checked %0d results, %0d lookup hits, %0d compiles",
             n_sent, n_checked, n_hits, n_compiles);
    $display("refused pushes: %0d table full, %0d inverted range", n_full, n_inverted);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
